[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

[src/ssvf_pkg.sv]
// Package: types, constants and segment font for the seven-segment formatter.
package ssvf_pkg;

  localparam int VAL_W = 18;
  localparam int MAG_W = VAL_W - 1;
  localparam int PROD_W = 35;

  // Reciprocals for exact division of a 17-bit magnitude by a multiply and shift
  localparam logic [17:0] RECIP_10    = 18'd209716;
  localparam logic [17:0] RECIP_100   = 18'd167773;
  localparam logic [17:0] RECIP_1000  = 18'd134218;
  localparam logic [17:0] RECIP_10000 = 18'd107375;

  localparam logic [1:0] MODE_TEMP  = 2'd0;
  localparam logic [1:0] MODE_ROLL  = 2'd1;
  localparam logic [1:0] MODE_PITCH = 2'd2;
  localparam logic [1:0] MODE_BLANK = 2'd3;

  localparam logic [2:0] SEL_OFF = 3'b111;
  localparam logic [1:0] POS_GLYPH = 2'd3;

  localparam logic [6:0] GLYPH_BLANK = 7'h00;
  localparam logic [6:0] GLYPH_C     = 7'h58;
  localparam logic [6:0] GLYPH_BAR   = 7'h30;
  localparam logic [6:0] GLYPH_DASH  = 7'h40;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [13:0]      q10;
    logic [10:0]      q100;
    logic [7:0]       q1000;
    logic [3:0]       q10000;
    logic             lt1000;
    logic             lt10000;
  } ssvf_quot_t;

  function automatic logic [6:0] seg_font(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

[src/seven_segment_value_formatter_unit.sv]
// Top level: seven-segment value formatter, one digit refresh per item.
//
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_ready  | value_hundredths, digit_select, mode
//  out     | from block| out_valid/out_ready| digit_enables, segment_lines,
//          |           |                    | lower_dot, upper_dot
//
// Three register stages: input, quotients, result/latches. One item per cycle
// sustained while the output is not stalled; the constant-divisor multipliers
// set the middle stage. The result register is the display latch set itself;
// it updates as an item lands, segments and dot only if non-negative, select[2] low.
// Synchronous reset clears valids and latches. Back-pressure stalls each stage
// only when the stage after it is full and not moving.
`include "assert_macros.svh"
module seven_segment_value_formatter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ssvf_pkg::VAL_W-1:0] value_hundredths,
  input  logic signed [2:0]             digit_select,
  input  logic [1:0]                    mode,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    digit_enables,
  output logic [6:0]                    segment_lines,
  output logic                          lower_dot,
  output logic                          upper_dot
);
  import ssvf_pkg::*;

  logic             s1_valid;
  logic [VAL_W-1:0] s1_val;
  logic [2:0]       s1_sel;
  logic [1:0]       s1_mode;

  logic             s2_valid;
  ssvf_quot_t       s2_quot;
  logic [2:0]       s2_sel;
  logic [1:0]       s2_mode;
  logic             s2_neg;

  logic [3:0]       enable_latch;
  logic [6:0]       segment_latch;
  logic             dot_latch;

  logic             adv1;
  logic             adv2;
  logic             adv3;
  ssvf_quot_t       quot;
  logic [6:0]       seg;
  logic             dot;
  logic [1:0]       prev_pos;
  logic             sel_pos;
  logic [3:0]       enable_next;

  assign adv3     = s2_valid && (!out_valid || out_ready);
  assign adv2     = s1_valid && (!s2_valid || adv3);
  assign in_ready = !s1_valid || adv2;
  assign adv1     = in_valid && in_ready;

  ssvf_quot u_quot (
    .mag  (s1_val[MAG_W-1:0]),
    .quot (quot)
  );

  ssvf_glyph u_glyph (
    .quot (s2_quot),
    .pos  (s2_sel[1:0]),
    .mode (s2_mode),
    .seg  (seg),
    .dot  (dot)
  );

  assign sel_pos  = !s2_sel[2];
  assign prev_pos = s2_sel[1:0] - 2'd1;

  always_comb begin
    enable_next = enable_latch;
    if (s2_sel == SEL_OFF) begin
      enable_next = 4'd0;
    end else if (sel_pos) begin
      enable_next = (enable_latch & ~(4'd1 << prev_pos)) | (4'd1 << s2_sel[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (adv1) begin
      s1_val  <= value_hundredths;
      s1_sel  <= digit_select;
      s1_mode <= mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || adv3) begin
      s2_valid <= s1_valid;
    end
    if (adv2) begin
      s2_quot <= quot;
      s2_sel  <= s1_sel;
      s2_mode <= s1_mode;
      s2_neg  <= s1_val[VAL_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      enable_latch  <= 4'd0;
      segment_latch <= 7'd0;
      dot_latch     <= 1'b0;
    end else begin
      if (adv3) begin
        out_valid    <= 1'b1;
        enable_latch <= enable_next;
        // negative values move the enables only
        if (sel_pos && !s2_neg) begin
          segment_latch <= seg;
          dot_latch     <= dot;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign digit_enables = enable_latch;
  assign segment_lines = segment_latch;
  assign lower_dot     = dot_latch;
  assign upper_dot     = 1'b0;

  `ASSERT_NEXT(a_off_clears, clk, rst, adv3 && (s2_sel == SEL_OFF), digit_enables == 4'd0)
  `ASSERT_NEXT(a_neg_keeps, clk, rst, adv3 && s2_neg, $stable(segment_lines) && $stable(lower_dot))
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, $stable(digit_enables) && out_valid)
  `ASSERT_IMPLY(a_glyph_nodot, clk, rst, adv3 && (s2_sel[1:0] == POS_GLYPH), !dot)

endmodule

[src/ssvf_quot.sv]
// Constant-divisor quotient unit: magnitude divided by 10, 100, 1000 and 10000.
module ssvf_quot (
  input  logic [ssvf_pkg::MAG_W-1:0] mag,
  output ssvf_pkg::ssvf_quot_t       quot
);
  import ssvf_pkg::*;

  logic [PROD_W-1:0] p10;
  logic [PROD_W-1:0] p100;
  logic [PROD_W-1:0] p1000;
  logic [PROD_W-1:0] p10000;

  assign p10    = PROD_W'(mag) * PROD_W'(RECIP_10);
  assign p100   = PROD_W'(mag) * PROD_W'(RECIP_100);
  assign p1000  = PROD_W'(mag) * PROD_W'(RECIP_1000);
  assign p10000 = PROD_W'(mag) * PROD_W'(RECIP_10000);

  always_comb begin
    quot.mag     = mag;
    quot.q10     = p10[34:21];
    quot.q100    = p100[34:24];
    quot.q1000   = p1000[34:27];
    quot.q10000  = p10000[33:30];
    quot.lt1000  = (mag < MAG_W'(1000));
    quot.lt10000 = (mag < MAG_W'(10000));
  end

endmodule

[src/ssvf_glyph.sv]
// Digit pick and segment pattern for one display position.
module ssvf_glyph (
  input  ssvf_pkg::ssvf_quot_t quot,
  input  logic [1:0]           pos,
  input  logic [1:0]           mode,
  output logic [6:0]           seg,
  output logic                 dot
);
  import ssvf_pkg::*;

  logic [16:0] r_ones;
  logic [13:0] r_tenths;
  logic [10:0] r_whole;
  logic [7:0]  r_tens;
  logic [3:0]  r_hund;
  logic [3:0]  digit;
  logic        num_dot;

  // remainders from the registered quotients
  assign r_ones   = quot.mag - 17'(quot.q10) * 17'd10;
  assign r_tenths = quot.q10 - 14'(quot.q100) * 14'd10;
  assign r_whole  = quot.q100 - 11'(quot.q1000) * 11'd10;
  assign r_tens   = quot.q1000 - 8'(quot.q10000) * 8'd10;
  assign r_hund   = (quot.q10000 >= 4'd10) ? quot.q10000 - 4'd10 : quot.q10000;

  always_comb begin
    digit   = 4'd0;
    num_dot = 1'b0;
    priority if (quot.lt1000) begin
      unique case (pos)
        2'd0:    begin digit = quot.q100[3:0]; num_dot = 1'b1; end
        2'd1:    digit = r_tenths[3:0];
        default: digit = r_ones[3:0];
      endcase
    end else if (quot.lt10000) begin
      unique case (pos)
        2'd0:    digit = quot.q1000[3:0];
        2'd1:    begin digit = r_whole[3:0]; num_dot = 1'b1; end
        default: digit = r_tenths[3:0];
      endcase
    end else begin
      unique case (pos)
        2'd0:    digit = r_hund;
        2'd1:    digit = r_tens[3:0];
        default: digit = r_whole[3:0];
      endcase
    end
  end

  always_comb begin
    seg = GLYPH_BLANK;
    dot = 1'b0;
    priority if (mode == MODE_BLANK) begin
      seg = GLYPH_BLANK;
    end else if (pos == POS_GLYPH) begin
      unique case (mode)
        MODE_TEMP:  seg = GLYPH_C;
        MODE_ROLL:  seg = GLYPH_BAR;
        MODE_PITCH: seg = GLYPH_DASH;
        default:    seg = GLYPH_BLANK;
      endcase
    end else begin
      seg = seg_font(digit);
      dot = num_dot;
    end
  end

endmodule
